FILE: hw/rtl/mme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants of the matrix multiply engine
// Request codes, register indexes, field widths and the cell link format.
// ----------------------------------------------------------------------------
package mme_pkg;

   // hard cap on any dimension: row and column indexes are 4 bits
   localparam int DIM_CAP         = 16;
   localparam int MAX_DIM_DEFAULT = 16;

   localparam int DIM_W  = 5;
   localparam int IDX_W  = 4;
   localparam int ELEM_W = 16;
   localparam int PROD_W = 32;
   localparam int ACC_W  = 40;
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [1:0] REQ_WRITE_A = 2'd0;
   localparam logic [1:0] REQ_WRITE_B = 2'd1;
   localparam logic [1:0] REQ_COMPUTE = 2'd2;

   localparam logic [1:0] REG_ROWS_A    = 2'd0;
   localparam logic [1:0] REG_INNER_DIM = 2'd1;
   localparam logic [1:0] REG_COLS_B    = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_ISSUE,
      SEQ_DRAIN
   } seq_state_type;

   // one step of a dot product travelling down the cell chain
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] k;
      logic             first;
      logic             last;
      logic             kill;
   } token_type;

   typedef struct packed {
      token_type               tok;
      logic signed [ELEM_W-1:0] a;
   } link_type;

endpackage

FILE: hw/rtl/matrix_multiply_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_engine: C = A x B over signed Q8.8 elements
// A store, a sequencer and a chain of column cells that each own one column
// of B and accumulate one Q16.16 dot product in 40 bits.
// ----------------------------------------------------------------------------
// Usage:
//  - Request beats are taken when start is high and busy is low. req_type
//    selects write A, write B or compute row. Writes never raise busy.
//  - A compute for a valid row raises busy and emits cols_b result beats,
//    one per cycle in column order, each flagged by rsp_valid for a single
//    cycle; rsp_row_last marks the final column. There is no backpressure:
//    the receiver must take every beat as it comes.
//  - A compute occupies the block while the sequencer walks the inner index
//    one term per cycle and then while the cell chain drains (one stage per
//    column cell, four cell pipeline stages).
//  - Rows at or beyond rows_a, or cols_b of zero, give no results.
//  - Registers rows_a, inner_dim, cols_b sit at APB byte addresses 0, 4, 8
//    and must be written only while busy is low; the block does not enforce it.
//  - Reset (synchronous) idles the sequencer, drops in-flight beats and
//    sets all dimensions to 16. Stores are not cleared.
// ----------------------------------------------------------------------------
module matrix_multiply_engine #(
   parameter int MAX_DIM = mme_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_type,
   input  logic [mme_pkg::IDX_W-1:0]           req_row_index,
   input  logic [mme_pkg::IDX_W-1:0]           req_col_index,
   input  logic signed [mme_pkg::ELEM_W-1:0]   req_elem_value,
   // result channel
   output logic                                rsp_valid,
   output logic [mme_pkg::IDX_W-1:0]           rsp_out_col,
   output logic signed [mme_pkg::ACC_W-1:0]    rsp_dot_value,
   output logic                                rsp_row_last,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mme_pkg::CSR_AW-1:0]          paddr,
   input  logic [mme_pkg::CSR_DW-1:0]          pwdata,
   output logic [mme_pkg::CSR_DW-1:0]          prdata,
   output logic                                pready
);
   import mme_pkg::*;

   // usable dimension: limited by the parameter and by 4-bit indexes
   localparam int LIM = (MAX_DIM < DIM_CAP) ? MAX_DIM : DIM_CAP;
   localparam int AAW = (LIM * LIM > 1) ? $clog2(LIM * LIM) : 1;
   localparam int BAW = (LIM > 1) ? $clog2(LIM) : 1;

   // ---------------- configuration registers ----------------
   logic [DIM_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic             csr_wr;
   logic [1:0]       csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_RESET;
         inner_dim_ff <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ROWS_A:    rows_a_ff    <= pwdata[DIM_W-1:0];
            REG_INNER_DIM: inner_dim_ff <= pwdata[DIM_W-1:0];
            REG_COLS_B:    cols_b_ff    <= pwdata[DIM_W-1:0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ROWS_A:    prdata = CSR_DW'(rows_a_ff);
         REG_INNER_DIM: prdata = CSR_DW'(inner_dim_ff);
         REG_COLS_B:    prdata = CSR_DW'(cols_b_ff);
         default:       prdata = '0;
      endcase
   end

   // effective dimensions
   logic [DIM_W-1:0] nr, nk, nc;
   assign nr = (rows_a_ff    > DIM_W'(LIM)) ? DIM_W'(LIM) : rows_a_ff;
   assign nk = (inner_dim_ff > DIM_W'(LIM)) ? DIM_W'(LIM) : inner_dim_ff;
   assign nc = (cols_b_ff    > DIM_W'(LIM)) ? DIM_W'(LIM) : cols_b_ff;

   // ---------------- request decode ----------------
   logic       req_take;
   logic       in_range;
   logic       a_we, b_wr, go;
   logic [7:0] a_widx;

   assign req_take = start & ~busy;
   assign in_range = (int'(req_row_index) < LIM) && (int'(req_col_index) < LIM);
   assign a_we     = req_take && (req_type == REQ_WRITE_A) && in_range;
   assign b_wr     = req_take && (req_type == REQ_WRITE_B) && in_range;
   assign go       = req_take && (req_type == REQ_COMPUTE) &&
                     ({1'b0, req_row_index} < nr) && (nc != '0);
   assign a_widx   = 8'(int'(req_row_index) * LIM + int'(req_col_index));

   // ---------------- A store and sequencer ----------------
   logic [AAW-1:0]    a_raddr;
   logic [ELEM_W-1:0] a_rdata;
   token_type         seq_tok;

   mme_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (LIM * LIM)
   ) u_a_store (
      .clock (clock),
      .we    (a_we),
      .waddr (a_widx[AAW-1:0]),
      .wdata (req_elem_value),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   mme_seq #(
      .DIM (LIM)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .go_row  (req_row_index),
      .go_nk   (nk),
      .busy    (busy),
      .rd_addr (a_raddr),
      .tok_o   (seq_tok)
   );

   // ---------------- cell chain ----------------
   // A beats enter cell 0 and shift one cell per cycle, so cell j finishes
   // in the cycle after cell j-1: results leave in column order.
   link_type                link [LIM+1];
   logic signed [ACC_W-1:0] cell_acc [LIM];
   logic [LIM-1:0]          cell_done;

   assign link[0].tok = seq_tok;
   assign link[0].a   = $signed(a_rdata);

   for (genvar j = 0; j < LIM; j++) begin : g_cell
      mme_cell #(
         .DIM (LIM)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .link_i  (link[j]),
         .link_o  (link[j+1]),
         .b_we    (b_wr && (req_col_index == IDX_W'(j))),
         .b_waddr (req_row_index[BAW-1:0]),
         .b_wdata (req_elem_value),
         .acc_o   (cell_acc[j]),
         .done_o  (cell_done[j])
      );
   end

   // ---------------- result register ----------------
   logic                    sel_valid;
   logic [IDX_W-1:0]        sel_col;
   logic signed [ACC_W-1:0] sel_dot;
   logic                    sel_last;
   logic                    rsp_valid_ff;
   logic [IDX_W-1:0]        rsp_col_ff;
   logic signed [ACC_W-1:0] rsp_dot_ff;
   logic                    rsp_last_ff;

   // at most one cell completes per cycle; columns past cols_b are dropped
   always_comb begin
      sel_valid = 1'b0;
      sel_col   = '0;
      sel_dot   = '0;
      sel_last  = 1'b0;
      for (int j = 0; j < LIM; j++) begin
         if (cell_done[j] && (DIM_W'(j) < nc)) begin
            sel_valid = 1'b1;
            sel_col   = sel_col | IDX_W'(j);
            sel_dot   = sel_dot | cell_acc[j];
            sel_last  = sel_last | (DIM_W'(j + 1) == nc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sel_valid;
      end
      rsp_col_ff  <= sel_col;
      rsp_dot_ff  <= sel_dot;
      rsp_last_ff <= sel_last;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_dot_value = rsp_dot_ff;
   assign rsp_row_last  = rsp_valid_ff & rsp_last_ff;

`ifndef SYNTHESIS
   a_done_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_done))
      else $error("two cells finished in the same cycle");

   a_rsp_in_job: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result beat outside a compute job");

   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      go |=> busy)
      else $error("accepted compute did not raise busy");

   a_tok_busy: assert property (@(posedge clock) disable iff (reset)
      seq_tok.valid |-> busy)
      else $error("chain beat launched while idle");
`endif

endmodule

FILE: hw/rtl/mme_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/mme_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_cell: one column cell of the multiply chain
// Holds one column of B, multiplies the passing A element by B[k][col],
// accumulates the dot product and forwards the A beat to its neighbor.
// ----------------------------------------------------------------------------
module mme_cell #(
   parameter int DIM = 16,
   localparam int BAW = (DIM > 1) ? $clog2(DIM) : 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mme_pkg::link_type                     link_i,
   output mme_pkg::link_type                     link_o,
   input  logic                                  b_we,
   input  logic [BAW-1:0]                        b_waddr,
   input  logic signed [mme_pkg::ELEM_W-1:0]     b_wdata,
   output logic signed [mme_pkg::ACC_W-1:0]      acc_o,
   output logic                                  done_o
);
   import mme_pkg::*;

   link_type                 in_ff;
   token_type                s2_tok_ff;
   logic signed [ELEM_W-1:0] s2_a_ff;
   token_type                s3_tok_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     done_ff;
   logic [ELEM_W-1:0]        b_rdata;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  prod_ext;

   mme_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DIM)
   ) u_b_col (
      .clock (clock),
      .we    (b_we),
      .waddr (b_waddr),
      .wdata (b_wdata),
      .raddr (in_ff.tok.k[BAW-1:0]),
      .rdata (b_rdata)
   );

   assign prod_in  = PROD_W'(s2_a_ff) * PROD_W'($signed(b_rdata));
   assign prod_ext = ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.tok.valid <= 1'b0;
         s2_tok_ff.valid <= 1'b0;
         s3_tok_ff.valid <= 1'b0;
         done_ff         <= 1'b0;
      end else begin
         in_ff     <= link_i;
         s2_tok_ff <= in_ff.tok;
         s3_tok_ff <= s2_tok_ff;
         done_ff   <= s3_tok_ff.valid & s3_tok_ff.last;
      end
      s2_a_ff <= in_ff.a;
      // empty inner dimension: force the term to zero
      prod_ff <= s2_tok_ff.kill ? '0 : prod_in;
      if (s3_tok_ff.valid) begin
         acc_ff <= s3_tok_ff.first ? prod_ext : acc_ff + prod_ext;
      end
   end

   assign link_o = in_ff;
   assign acc_o  = acc_ff;
   assign done_o = done_ff;

endmodule

FILE: hw/rtl/mme_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mme_seq: row sequencer
// Walks the inner index of one result row, reads A and launches one beat
// per term into the cell chain, then waits for the chain to drain.
// ----------------------------------------------------------------------------
module mme_seq #(
   parameter int DIM = 16,
   localparam int AAW = (DIM * DIM > 1) ? $clog2(DIM * DIM) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [mme_pkg::IDX_W-1:0]     go_row,
   input  logic [mme_pkg::DIM_W-1:0]     go_nk,
   output logic                          busy,
   output logic [AAW-1:0]                rd_addr,
   output mme_pkg::token_type            tok_o
);
   import mme_pkg::*;

   localparam int DRAIN_CYC = DIM + 4;
   localparam int DW        = $clog2(DRAIN_CYC);

   seq_state_type    state_ff, state_in;
   logic [IDX_W-1:0] row_ff;
   logic [DIM_W-1:0] nk_ff;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [DW-1:0]    drain_ff, drain_in;
   token_type        tok_ff, tok_in;
   logic             last_k;
   logic [7:0]       addr_full;

   assign last_k = (nk_ff == '0) || ({1'b0, k_ff} == nk_ff - DIM_W'(1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (go) begin
               state_in = SEQ_ISSUE;
            end
         end
         SEQ_ISSUE: begin
            if (last_k) begin
               state_in = SEQ_DRAIN;
            end
         end
         SEQ_DRAIN: begin
            if (drain_ff == '0) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      k_in      = k_ff;
      drain_in  = drain_ff;
      tok_in    = '0;
      addr_full = 8'(int'(row_ff) * DIM + int'(k_ff));
      case (state_ff)
         SEQ_IDLE: begin
            k_in = '0;
         end
         SEQ_ISSUE: begin
            tok_in.valid = 1'b1;
            tok_in.k     = k_ff;
            tok_in.first = (k_ff == '0);
            tok_in.last  = last_k;
            tok_in.kill  = (nk_ff == '0);
            k_in         = k_ff + IDX_W'(1);
            drain_in     = DW'(DRAIN_CYC - 1);
         end
         SEQ_DRAIN: begin
            drain_in = drain_ff - DW'(1);
         end
         default: begin
            k_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         tok_ff.valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         tok_ff   <= tok_in;
      end
      k_ff     <= k_in;
      drain_ff <= drain_in;
      if (go && state_ff == SEQ_IDLE) begin
         row_ff <= go_row;
         nk_ff  <= go_nk;
      end
   end

   assign busy    = (state_ff != SEQ_IDLE);
   assign rd_addr = addr_full[AAW-1:0];
   assign tok_o   = tok_ff;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for matrix_multiply_engine
// Drives element writes and row computes through the start/busy channel and
// sets the three dimension registers over APB. A shadow copy of both stores
// predicts every result beat of C = A x B, and a monitor checks each beat
// against the oldest prediction. Computes only ever read entries the bench
// has written, so operands are filled on demand before a compute.
// ----------------------------------------------------------------------------
module tb_top;
   import mme_pkg::*;

   // worst busy time of one compute, rounded up
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [IDX_W-1:0]         col;
      logic signed [ACC_W-1:0]  dot;
      logic                     last;
   } dot_beat_type;

   // -------------------------------------------------------------------------
   // Shadow stores, shadow dimension registers and the queue of row beats
   // still owed by the block.
   // -------------------------------------------------------------------------
   class dot_board_type;
      logic signed [ELEM_W-1:0] a_mat [DIM_CAP][DIM_CAP];
      logic signed [ELEM_W-1:0] b_mat [DIM_CAP][DIM_CAP];
      bit                       a_known [DIM_CAP][DIM_CAP];
      bit                       b_known [DIM_CAP][DIM_CAP];
      logic [DIM_W-1:0]         dim_reg [3];
      dot_beat_type             pending_dots [$];
      int                       errors;

      function new();
         dim_reg = '{DIM_RESET, DIM_RESET, DIM_RESET};
         errors  = 0;
      endfunction

      function void set_dim(input logic [1:0] index, input logic [DIM_W-1:0] value);
         if (index <= REG_COLS_B)
            dim_reg[index] = value;
      endfunction

      // register value clamped to the array size
      function int eff_dim(input logic [1:0] index);
         int v;
         v = int'(dim_reg[index]);
         return (v > DIM_CAP) ? DIM_CAP : v;
      endfunction

      // accepted request beat: update the stores or predict one row of C
      function void note_request(input logic [1:0] kind, input logic [IDX_W-1:0] row,
                                 input logic [IDX_W-1:0] col,
                                 input logic signed [ELEM_W-1:0] value);
         int           nr, nk, nc;
         longint       acc;
         dot_beat_type beat;
         case (kind)
            REQ_WRITE_A: begin
               a_mat[row][col]   = value;
               a_known[row][col] = 1'b1;
            end
            REQ_WRITE_B: begin
               b_mat[row][col]   = value;
               b_known[row][col] = 1'b1;
            end
            REQ_COMPUTE: begin
               nr = eff_dim(REG_ROWS_A);
               nk = eff_dim(REG_INNER_DIM);
               nc = eff_dim(REG_COLS_B);
               if (row < nr) begin
                  for (int j = 0; j < nc; j++) begin
                     acc = 0;
                     for (int k = 0; k < nk; k++)
                        acc += longint'(a_mat[row][k]) * longint'(b_mat[k][j]);
                     beat.col  = IDX_W'(j);
                     beat.dot  = acc[ACC_W-1:0];
                     beat.last = (j == nc - 1);
                     pending_dots.push_back(beat);
                  end
               end
            end
            default: ;  // unused code: no effect
         endcase
      endfunction

      function void check_beat(input logic [IDX_W-1:0] col,
                               input logic signed [ACC_W-1:0] dot, input logic last);
         dot_beat_type want;
         if (pending_dots.size() == 0) begin
            $error("unexpected result beat: out_col %0d dot_value %0d", col, dot);
            errors++;
            return;
         end
         want = pending_dots.pop_front();
         if (col !== want.col) begin
            $error("out_col mismatch: expected %0d, got %0d", want.col, col);
            errors++;
         end
         if (dot !== want.dot) begin
            $error("dot_value mismatch: expected %0d, got %0d", want.dot, dot);
            errors++;
         end
         if (last !== want.last) begin
            $error("row_last mismatch: expected %0d, got %0d", want.last, last);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [1:0]                req_type;
   logic [IDX_W-1:0]          req_row_index;
   logic [IDX_W-1:0]          req_col_index;
   logic signed [ELEM_W-1:0]  req_elem_value;
   logic                      rsp_valid;
   logic [IDX_W-1:0]          rsp_out_col;
   logic signed [ACC_W-1:0]   rsp_dot_value;
   logic                      rsp_row_last;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_AW-1:0]         paddr;
   logic [CSR_DW-1:0]         pwdata;
   logic [CSR_DW-1:0]         prdata;
   logic                      pready;

   dot_board_type board = new();
   int            gap_odds;    // 0: no sender gaps, else one chance in gap_odds per beat
   int            sent_count;  // request beats accepted so far, operand fills included

   matrix_multiply_engine dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_row_index  (req_row_index),
      .req_col_index  (req_col_index),
      .req_elem_value (req_elem_value),
      .rsp_valid      (rsp_valid),
      .rsp_out_col    (rsp_out_col),
      .rsp_dot_value  (rsp_dot_value),
      .rsp_row_last   (rsp_row_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result monitor: no backpressure, so every strobed beat is taken here
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_beat(rsp_out_col, rsp_dot_value, rsp_row_last);
   end

   // -------------------------------------------------------------------------
   // Drivers: inputs move on the falling edge, handshakes resolve on the
   // rising edge.
   // -------------------------------------------------------------------------

   // leaves start high after the beat is taken; the next negedge either
   // presents a new beat or drops start
   task automatic send_request(input logic [1:0] kind, input logic [IDX_W-1:0] row,
                               input logic [IDX_W-1:0] col,
                               input logic signed [ELEM_W-1:0] value);
      @(negedge clock);
      start          <= 1'b1;
      req_type       <= kind;
      req_row_index  <= row;
      req_col_index  <= col;
      req_elem_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(kind, row, col, value);
      sent_count++;
   endtask

   // idle burst of random length with junk on the payload
   task automatic sender_gap();
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         repeat ($urandom_range(1, 6)) begin
            @(negedge clock);
            start          <= 1'b0;
            req_type       <= 2'($urandom);
            req_row_index  <= IDX_W'($urandom);
            req_col_index  <= IDX_W'($urandom);
            req_elem_value <= ELEM_W'($urandom);
         end
      end
   endtask

   // APB write, then a read back of the same register
   task automatic csr_write(input logic [1:0] index, input logic [CSR_DW-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.set_dim(index, value[DIM_W-1:0]);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (index <= REG_COLS_B && prdata !== CSR_DW'(board.dim_reg[index])) begin
         $error("prdata mismatch: expected %0d, got %0d", board.dim_reg[index], prdata);
         board.errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // block idle: all owed beats seen, then room for a compute with no results
   task automatic quiesce();
      @(negedge clock);
      start <= 1'b0;
      while (board.pending_dots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic signed [ELEM_W-1:0] rand_elem();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return -16'sd1;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   // write every operand of row 'row' that has never been written
   task automatic fill_operands(input logic [IDX_W-1:0] row);
      int nk, nc;
      nk = board.eff_dim(REG_INNER_DIM);
      nc = board.eff_dim(REG_COLS_B);
      for (int k = 0; k < nk; k++) begin
         if (!board.a_known[row][k]) begin
            sender_gap();
            send_request(REQ_WRITE_A, row, IDX_W'(k), rand_elem());
         end
         for (int j = 0; j < nc; j++) begin
            if (!board.b_known[k][j]) begin
               sender_gap();
               send_request(REQ_WRITE_B, IDX_W'(k), IDX_W'(j), rand_elem());
            end
         end
      end
   endtask

   task automatic random_item();
      int               pick, nr;
      logic [IDX_W-1:0] row;
      logic [1:0]       kind;
      pick = $urandom_range(0, 99);
      nr   = board.eff_dim(REG_ROWS_A);
      if (pick < 45) begin
         // mostly rows in range; the rest may fall past rows_a
         if (nr > 0 && $urandom_range(0, 4) != 0)
            row = IDX_W'($urandom_range(0, nr - 1));
         else
            row = IDX_W'($urandom);
         if (row < nr)
            fill_operands(row);
         sender_gap();
         send_request(REQ_COMPUTE, row, IDX_W'($urandom), ELEM_W'($urandom));
      end else begin
         if (pick < 93)
            kind = $urandom_range(0, 1) ? REQ_WRITE_B : REQ_WRITE_A;
         else
            kind = 2'd3;  // unused code, no effect
         sender_gap();
         send_request(kind, IDX_W'($urandom), IDX_W'($urandom), rand_elem());
      end
   endtask

   // count: request beats sent in this phase, operand fills included
   task automatic run_phase(input int rows, input int inner, input int cols,
                            input int count, input int odds);
      int stop;
      quiesce();
      csr_write(REG_ROWS_A, rows);
      csr_write(REG_INNER_DIM, inner);
      csr_write(REG_COLS_B, cols);
      gap_odds = odds;
      stop     = sent_count + count;
      while (sent_count < stop) random_item();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_type       = REQ_WRITE_A;
      req_row_index  = '0;
      req_col_index  = '0;
      req_elem_value = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      gap_odds       = 0;
      sent_count     = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: 2x2 times 2x3 with full-scale operands
      csr_write(REG_ROWS_A, 2);
      csr_write(REG_INNER_DIM, 2);
      csr_write(REG_COLS_B, 3);
      csr_write(2'd3, 5);  // no register at this address: ignored
      send_request(REQ_WRITE_A, 0, 0, 16'sh8000);
      send_request(REQ_WRITE_A, 0, 1, 16'sh8000);
      send_request(REQ_WRITE_A, 1, 0, 16'sh7FFF);
      send_request(REQ_WRITE_A, 1, 1, -16'sd1);
      send_request(REQ_WRITE_B, 0, 0, 16'sh8000);
      send_request(REQ_WRITE_B, 1, 0, 16'sh8000);
      send_request(REQ_WRITE_B, 0, 1, 16'sh7FFF);
      send_request(REQ_WRITE_B, 1, 1, 16'sh7FFF);
      send_request(REQ_WRITE_B, 0, 2, 16'sh0000);
      send_request(REQ_WRITE_B, 1, 2, 16'sh0001);
      send_request(REQ_WRITE_A, 15, 15, 16'sh7FFF);
      send_request(REQ_WRITE_B, 15, 15, 16'sh8000);
      send_request(REQ_COMPUTE, 0, 0, 16'sh0000);
      send_request(REQ_COMPUTE, 1, 15, -16'sd1);
      send_request(REQ_COMPUTE, 2, 0, 16'sh0000);   // row past rows_a: silent
      send_request(REQ_COMPUTE, 15, 0, 16'sh0000);  // same, top row index
      send_request(2'd3, 15, 15, 16'sh8000);        // unused code

      // register extremes, then random settings; last phases run flat out
      run_phase(1, 1, 1, 20, 3);
      run_phase(16, 16, 1, 40, 2);    // longest dot product
      run_phase(3, 2, 16, 35, 2);     // full chain width
      run_phase(0, 5, 3, 15, 4);      // no rows: computes stay silent
      run_phase(5, 0, 6, 15, 0);      // empty inner sum: all zeros
      run_phase(6, 4, 0, 15, 3);      // no columns: computes stay silent
      run_phase(31, 2, 31, 30, 2);    // rows and columns beyond range: clamp to 16
      run_phase(2, 31, 1, 30, 4);     // inner beyond range: clamps to 16
      run_phase($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 2), 25, 3);
      run_phase($urandom_range(1, 16), $urandom_range(1, 3), $urandom_range(1, 16), 25, 2);
      run_phase($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 2), 25, 0);
      run_phase($urandom_range(1, 16), $urandom_range(1, 3), $urandom_range(1, 16), 25, 0);

      quiesce();
      if (board.errors == 0 && board.pending_dots.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
